// ===== hw/rtl/cts_pkg.sv =====
`default_nettype none
package cts_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ID_W       = 16;
    localparam int TIME_W     = 32;
    localparam int TICK_W     = 32;
    localparam int REQ_W      = 4;
    localparam int OUT_SLOT_W = 3;

    typedef enum logic [2:0] {
        ST_FREE      = 3'd0,
        ST_READY     = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_SLEEPING  = 3'd3,
        ST_FINISHED  = 3'd4,
        ST_CANCELLED = 3'd5
    } slot_st_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_SPAWN        = 4'd0,
        REQ_TICK         = 4'd1,
        REQ_DISPATCH     = 4'd2,
        REQ_STEP_DONE    = 4'd3,
        REQ_YIELD        = 4'd4,
        REQ_SLEEP        = 4'd5,
        REQ_EXIT         = 4'd6,
        REQ_KILL         = 4'd7,
        REQ_CANCEL       = 4'd8,
        REQ_CLEAR_CANCEL = 4'd9
    } req_t;

    typedef struct packed {
        logic              used;
        logic [ID_W-1:0]   id;
        slot_st_t          st;
        logic              fg;
        logic              cancel;
        logic [TIME_W-1:0] wake;
    } slot_ent_t;

    localparam int ENT_W = $bits(slot_ent_t);

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic              is_foreground;
        logic [TICK_W-1:0] sleep_ticks;
        logic [ID_W-1:0]   target_id;
        logic [TIME_W-1:0] now_time;
    } cmd_t;

    typedef struct packed {
        logic                  status;
        logic [ID_W-1:0]       task_id;
        logic [OUT_SLOT_W-1:0] task_slot;
        logic                  fg_done;
        logic [ID_W-1:0]       fg_done_id;
        logic                  fg_done_cancelled;
        logic                  cancel_flag;
        logic                  running;
        logic                  fg_active;
        logic                  any_ready;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'd0,
        S_IDLE   = 3'd1,
        S_SCAN_A = 3'd2,
        S_DECIDE = 3'd3,
        S_ACT    = 3'd4,
        S_SCAN_B = 3'd5,
        S_OUT    = 3'd6
    } ctl_st_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctl_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cts_if.sv =====
`default_nettype none
interface cts_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [cts_pkg::REQ_W-1:0]   req_type;
    logic                        is_foreground;
    logic [cts_pkg::TICK_W-1:0]  sleep_ticks;
    logic [cts_pkg::ID_W-1:0]    target_id;
    logic [cts_pkg::TIME_W-1:0]  now_time;

    modport source (output valid, req_type, is_foreground, sleep_ticks, target_id, now_time,
                    input ready);
    modport sink   (input valid, req_type, is_foreground, sleep_ticks, target_id, now_time,
                    output ready);
endinterface

interface cts_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [cts_pkg::ID_W-1:0]       task_id;
    logic [cts_pkg::OUT_SLOT_W-1:0] task_slot;
    logic                           fg_done;
    logic [cts_pkg::ID_W-1:0]       fg_done_id;
    logic                           fg_done_cancelled;
    logic                           cancel_flag;
    logic                           running;
    logic                           fg_active;
    logic                           any_ready;

    modport source (output valid, status, task_id, task_slot, fg_done, fg_done_id,
                    fg_done_cancelled, cancel_flag, running, fg_active, any_ready,
                    input ready);
    modport sink   (input valid, status, task_id, task_slot, fg_done, fg_done_id,
                    fg_done_cancelled, cancel_flag, running, fg_active, any_ready,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cts_ram.sv =====
`default_nettype none
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cts_ctrl.sv =====
`default_nettype none
module cts_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  cts_pkg::cmd_t                  cmd,
    input  logic                           out_free,
    output cts_pkg::ctl_stat_t             stat,
    output cts_pkg::rsp_t                  rsp,
    output logic                           ram_we,
    output logic [cts_pkg::SLOT_W-1:0]     ram_waddr,
    output cts_pkg::slot_ent_t             ram_wdata,
    output logic [cts_pkg::SLOT_W-1:0]     ram_raddr,
    input  cts_pkg::slot_ent_t             ram_rdata
);

    localparam int SW = cts_pkg::SLOT_W;
    localparam int CW = cts_pkg::CNT_W;
    localparam int IW = cts_pkg::ID_W;
    localparam int TW = cts_pkg::TIME_W;

    cts_pkg::ctl_st_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [SW-1:0] cur_slot_reg, cur_slot_next;
    logic [SW-1:0] rr_reg, rr_next;
    logic [IW-1:0] next_id_reg, next_id_next;
    logic          fg_valid_reg, fg_valid_next;
    logic [IW-1:0] fg_id_reg, fg_id_next;
    logic          free_found_reg, free_found_next;
    logic [SW-1:0] free_idx_reg, free_idx_next;
    logic          hi_found_reg, hi_found_next;
    logic [SW-1:0] hi_idx_reg, hi_idx_next;
    logic          lo_found_reg, lo_found_next;
    logic [SW-1:0] lo_idx_reg, lo_idx_next;
    logic          m_found_reg, m_found_next;
    logic [SW-1:0] m_idx_reg, m_idx_next;
    logic [SW-1:0] tgt_reg, tgt_next;
    logic          ok_reg, ok_next;
    logic          refused_reg, refused_next;
    logic [IW-1:0] act_id_reg, act_id_next;
    logic [SW-1:0] act_slot_reg, act_slot_next;
    logic          done_reg, done_next;
    logic [IW-1:0] done_id_reg, done_id_next;
    logic          done_cancel_reg, done_cancel_next;
    logic          any_ready_reg, any_ready_next;
    logic          fb_found_reg, fb_found_next;
    logic          fb_cancel_reg, fb_cancel_next;

    logic [CW-1:0]        cnt_m1;
    logic [SW-1:0]        idx;
    logic [IW-1:0]        key;
    logic [TW-1:0]        diff;
    logic [IW-1:0]        nid_inc;
    cts_pkg::slot_ent_t   ent;
    cts_pkg::slot_ent_t   ne;
    logic                 dec_ok;
    logic [SW-1:0]        dec_tgt;
    logic                 rt;
    logic                 rt_cancel;
    logic [SW+cts_pkg::OUT_SLOT_W-1:0] slot_ext;

    assign ent     = ram_rdata;
    assign cnt_m1  = cnt_reg - 1'b1;
    assign idx     = cnt_m1[SW-1:0];
    assign key     = (cmd.req_type == cts_pkg::REQ_KILL) ? cmd.target_id : fg_id_reg;
    assign diff    = cmd.now_time - ent.wake;
    assign nid_inc = next_id_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cts_pkg::S_CLEAR;
            cnt_reg         <= '0;
            cur_valid_reg   <= 1'b0;
            cur_slot_reg    <= '0;
            rr_reg          <= '0;
            next_id_reg     <= IW'(1);
            fg_valid_reg    <= 1'b0;
            fg_id_reg       <= '0;
            free_found_reg  <= 1'b0;
            hi_found_reg    <= 1'b0;
            lo_found_reg    <= 1'b0;
            m_found_reg     <= 1'b0;
            ok_reg          <= 1'b0;
            fb_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            cur_valid_reg   <= cur_valid_next;
            cur_slot_reg    <= cur_slot_next;
            rr_reg          <= rr_next;
            next_id_reg     <= next_id_next;
            fg_valid_reg    <= fg_valid_next;
            fg_id_reg       <= fg_id_next;
            free_found_reg  <= free_found_next;
            hi_found_reg    <= hi_found_next;
            lo_found_reg    <= lo_found_next;
            m_found_reg     <= m_found_next;
            ok_reg          <= ok_next;
            fb_found_reg    <= fb_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg    <= free_idx_next;
        hi_idx_reg      <= hi_idx_next;
        lo_idx_reg      <= lo_idx_next;
        m_idx_reg       <= m_idx_next;
        tgt_reg         <= tgt_next;
        refused_reg     <= refused_next;
        act_id_reg      <= act_id_next;
        act_slot_reg    <= act_slot_next;
        done_reg        <= done_next;
        done_id_reg     <= done_id_next;
        done_cancel_reg <= done_cancel_next;
        any_ready_reg   <= any_ready_next;
        fb_cancel_reg   <= fb_cancel_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cur_valid_next   = cur_valid_reg;
        cur_slot_next    = cur_slot_reg;
        rr_next          = rr_reg;
        next_id_next     = next_id_reg;
        fg_valid_next    = fg_valid_reg;
        fg_id_next       = fg_id_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        hi_found_next    = hi_found_reg;
        hi_idx_next      = hi_idx_reg;
        lo_found_next    = lo_found_reg;
        lo_idx_next      = lo_idx_reg;
        m_found_next     = m_found_reg;
        m_idx_next       = m_idx_reg;
        tgt_next         = tgt_reg;
        ok_next          = ok_reg;
        refused_next     = refused_reg;
        act_id_next      = act_id_reg;
        act_slot_next    = act_slot_reg;
        done_next        = done_reg;
        done_id_next     = done_id_reg;
        done_cancel_next = done_cancel_reg;
        any_ready_next   = any_ready_reg;
        fb_found_next    = fb_found_reg;
        fb_cancel_next   = fb_cancel_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx;
        ram_wdata        = ent;
        ram_raddr        = cnt_reg[SW-1:0];
        stat.idle        = 1'b0;
        stat.done        = 1'b0;
        dec_ok           = 1'b0;
        dec_tgt          = '0;
        ne               = ent;
        rt               = 1'b0;
        rt_cancel        = 1'b0;

        case (state_reg)
            cts_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[SW-1:0];
                ram_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(cts_pkg::SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = cts_pkg::S_IDLE;
                end
            end

            cts_pkg::S_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    hi_found_next   = 1'b0;
                    lo_found_next   = 1'b0;
                    m_found_next    = 1'b0;
                    state_next      = cts_pkg::S_SCAN_A;
                end
            end

            cts_pkg::S_SCAN_A:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    if (!ent.used && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx;
                    end
                    if (ent.used && ent.st == cts_pkg::ST_READY)
                    begin
                        if (idx >= rr_reg && !hi_found_reg)
                        begin
                            hi_found_next = 1'b1;
                            hi_idx_next   = idx;
                        end
                        if (!lo_found_reg)
                        begin
                            lo_found_next = 1'b1;
                            lo_idx_next   = idx;
                        end
                    end
                    if (ent.used && ent.id == key && !m_found_reg)
                    begin
                        m_found_next = 1'b1;
                        m_idx_next   = idx;
                    end
                    // A sleeper wakes once its wake time is not ahead of now, modulo wrap.
                    if (cmd.req_type == cts_pkg::REQ_TICK && ent.used &&
                        ent.st == cts_pkg::ST_SLEEPING && !diff[TW-1])
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = ent;
                        ram_wdata.st = cts_pkg::ST_READY;
                    end
                end
                if (cnt_reg == CW'(cts_pkg::SLOTS))
                begin
                    state_next = cts_pkg::S_DECIDE;
                end
            end

            cts_pkg::S_DECIDE:
            begin
                case (cmd.req_type)
                    cts_pkg::REQ_SPAWN:
                    begin
                        dec_ok  = free_found_reg && !(cmd.is_foreground && fg_valid_reg);
                        dec_tgt = free_idx_reg;
                    end
                    cts_pkg::REQ_DISPATCH:
                    begin
                        dec_ok  = !cur_valid_reg && (hi_found_reg || lo_found_reg);
                        dec_tgt = hi_found_reg ? hi_idx_reg : lo_idx_reg;
                    end
                    cts_pkg::REQ_STEP_DONE, cts_pkg::REQ_YIELD, cts_pkg::REQ_SLEEP,
                    cts_pkg::REQ_EXIT:
                    begin
                        dec_ok  = cur_valid_reg;
                        dec_tgt = cur_slot_reg;
                    end
                    cts_pkg::REQ_KILL:
                    begin
                        dec_ok  = m_found_reg;
                        dec_tgt = m_idx_reg;
                    end
                    cts_pkg::REQ_CANCEL, cts_pkg::REQ_CLEAR_CANCEL:
                    begin
                        dec_ok  = cur_valid_reg || (fg_valid_reg && m_found_reg);
                        dec_tgt = cur_valid_reg ? cur_slot_reg : m_idx_reg;
                    end
                    default:
                    begin
                        dec_ok  = 1'b0;
                        dec_tgt = '0;
                    end
                endcase
                ram_raddr    = dec_tgt;
                tgt_next     = dec_tgt;
                ok_next      = dec_ok;
                refused_next = !dec_ok && (cmd.req_type != cts_pkg::REQ_TICK);
                state_next   = cts_pkg::S_ACT;
            end

            cts_pkg::S_ACT:
            begin
                act_id_next      = '0;
                act_slot_next    = '0;
                done_next        = 1'b0;
                done_id_next     = '0;
                done_cancel_next = 1'b0;
                if (ok_reg)
                begin
                    act_slot_next = tgt_reg;
                    act_id_next   = ent.id;
                    case (cmd.req_type)
                        cts_pkg::REQ_SPAWN:
                        begin
                            ne        = '0;
                            ne.used   = 1'b1;
                            ne.id     = next_id_reg;
                            ne.st     = cts_pkg::ST_READY;
                            ne.fg     = cmd.is_foreground;
                            act_id_next  = next_id_reg;
                            next_id_next = (nid_inc == '0) ? IW'(1) : nid_inc;
                            if (cmd.is_foreground)
                            begin
                                fg_valid_next = 1'b1;
                                fg_id_next    = next_id_reg;
                            end
                        end
                        cts_pkg::REQ_DISPATCH:
                        begin
                            ne.st          = cts_pkg::ST_RUNNING;
                            rr_next        = (tgt_reg == SW'(cts_pkg::SLOTS - 1)) ?
                                             '0 : SW'(tgt_reg + 1'b1);
                            cur_valid_next = 1'b1;
                            cur_slot_next  = tgt_reg;
                        end
                        cts_pkg::REQ_STEP_DONE:
                        begin
                            cur_valid_next = 1'b0;
                            cur_slot_next  = '0;
                            if (ent.used && ent.st == cts_pkg::ST_RUNNING)
                            begin
                                ne.st = cts_pkg::ST_READY;
                            end
                            if (ent.used && (ent.st == cts_pkg::ST_FINISHED ||
                                             ent.st == cts_pkg::ST_CANCELLED))
                            begin
                                rt        = 1'b1;
                                rt_cancel = ent.cancel || ent.st == cts_pkg::ST_CANCELLED;
                            end
                        end
                        cts_pkg::REQ_YIELD:
                        begin
                            ne.st = cts_pkg::ST_READY;
                        end
                        cts_pkg::REQ_SLEEP:
                        begin
                            if (cmd.sleep_ticks == '0)
                            begin
                                ne.st = cts_pkg::ST_READY;
                            end
                            else
                            begin
                                ne.st   = cts_pkg::ST_SLEEPING;
                                ne.wake = TW'(cmd.now_time + cmd.sleep_ticks);
                            end
                        end
                        cts_pkg::REQ_EXIT:
                        begin
                            ne.st = cts_pkg::ST_FINISHED;
                        end
                        cts_pkg::REQ_KILL:
                        begin
                            ne.cancel = 1'b1;
                            if (ent.st != cts_pkg::ST_RUNNING)
                            begin
                                rt        = 1'b1;
                                rt_cancel = 1'b1;
                            end
                        end
                        cts_pkg::REQ_CANCEL:
                        begin
                            ne.cancel = 1'b1;
                            if (ent.st == cts_pkg::ST_SLEEPING)
                            begin
                                ne.st = cts_pkg::ST_READY;
                            end
                        end
                        cts_pkg::REQ_CLEAR_CANCEL:
                        begin
                            ne.cancel = 1'b0;
                        end
                        default:
                        begin
                            ne = ent;
                        end
                    endcase
                    // Retiring the foreground task reports its completion.
                    if (rt)
                    begin
                        if (ent.fg && fg_valid_reg && fg_id_reg == ent.id)
                        begin
                            fg_valid_next    = 1'b0;
                            done_next        = 1'b1;
                            done_id_next     = ent.id;
                            done_cancel_next = rt_cancel;
                        end
                        ne = '0;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = tgt_reg;
                    ram_wdata = ne;
                end
                cnt_next       = '0;
                any_ready_next = 1'b0;
                fb_found_next  = 1'b0;
                fb_cancel_next = 1'b0;
                state_next     = cts_pkg::S_SCAN_B;
            end

            cts_pkg::S_SCAN_B:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    if (ent.used && ent.st == cts_pkg::ST_READY)
                    begin
                        any_ready_next = 1'b1;
                    end
                    if (cur_valid_reg)
                    begin
                        if (idx == cur_slot_reg)
                        begin
                            fb_cancel_next = ent.cancel;
                        end
                    end
                    else if (fg_valid_reg && !fb_found_reg && ent.used && ent.id == fg_id_reg)
                    begin
                        fb_found_next  = 1'b1;
                        fb_cancel_next = ent.cancel;
                    end
                end
                if (cnt_reg == CW'(cts_pkg::SLOTS))
                begin
                    state_next = cts_pkg::S_OUT;
                end
            end

            cts_pkg::S_OUT:
            begin
                stat.done = out_free;
                if (out_free)
                begin
                    state_next = cts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cts_pkg::S_IDLE;
            end
        endcase
    end

    assign slot_ext = {{cts_pkg::OUT_SLOT_W{1'b0}}, act_slot_reg};

    always_comb
    begin
        rsp.status            = refused_reg;
        rsp.task_id           = act_id_reg;
        rsp.task_slot         = slot_ext[cts_pkg::OUT_SLOT_W-1:0];
        rsp.fg_done           = done_reg;
        rsp.fg_done_id        = done_id_reg;
        rsp.fg_done_cancelled = done_cancel_reg;
        rsp.cancel_flag       = fb_cancel_reg;
        rsp.running           = cur_valid_reg;
        rsp.fg_active         = fg_valid_reg;
        rsp.any_ready         = any_ready_reg;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cooperative_task_scheduler_core.sv =====
// Channel  Dir  Payload                                             Taken when
// cmd      in   req_type, is_foreground, sleep_ticks, target_id,    valid && ready
//               now_time
// rsp      out  status, task_id, task_slot, fg_done, fg_done_id,    valid && ready
//               fg_done_cancelled, cancel_flag, running, fg_active,
//               any_ready
//
// Each command passes through a read-modify-write pass over the slot RAM, a decision, one
// decided access, and a status pass before its result is offered; the next command is taken
// only once the engine is idle again, so the engine works on one command at a time.
// The slot RAM returns one entry per cycle to the passes.
// After reset a clearing pass writes every slot free; cmd.ready is low meanwhile.
// A result waits in the output register; the next command is taken meanwhile and its
// result stalls in the engine until the output register is free.
`default_nettype none
module cooperative_task_scheduler_core (
    input  logic       clk,
    input  logic       rst_n,
    cts_cmd_if.sink    cmd,
    cts_rsp_if.source  rsp
);

    cts_pkg::cmd_t      cmd_reg;
    cts_pkg::rsp_t      out_data_reg;
    logic               out_valid_reg;
    cts_pkg::rsp_t      eng_rsp;
    cts_pkg::ctl_stat_t stat;
    logic               accept;
    logic               out_free;
    logic               ram_we;
    logic [cts_pkg::SLOT_W-1:0] ram_waddr;
    logic [cts_pkg::SLOT_W-1:0] ram_raddr;
    cts_pkg::slot_ent_t ram_wdata;
    cts_pkg::slot_ent_t ram_rdata;
    logic [cts_pkg::ENT_W-1:0] ram_rbits;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = stat.idle;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.req_type      <= cmd.req_type;
            cmd_reg.is_foreground <= cmd.is_foreground;
            cmd_reg.sleep_ticks   <= cmd.sleep_ticks;
            cmd_reg.target_id     <= cmd.target_id;
            cmd_reg.now_time      <= cmd.now_time;
        end
        if (stat.done)
        begin
            out_data_reg <= eng_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    cts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .cmd       (cmd_reg),
        .out_free  (out_free),
        .stat      (stat),
        .rsp       (eng_rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cts_ram #(
        .WIDTH (cts_pkg::ENT_W),
        .DEPTH (cts_pkg::SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = ram_rbits;

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_data_reg.status;
    assign rsp.task_id           = out_data_reg.task_id;
    assign rsp.task_slot         = out_data_reg.task_slot;
    assign rsp.fg_done           = out_data_reg.fg_done;
    assign rsp.fg_done_id        = out_data_reg.fg_done_id;
    assign rsp.fg_done_cancelled = out_data_reg.fg_done_cancelled;
    assign rsp.cancel_flag       = out_data_reg.cancel_flag;
    assign rsp.running           = out_data_reg.running;
    assign rsp.fg_active         = out_data_reg.fg_active;
    assign rsp.any_ready         = out_data_reg.any_ready;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !stat.idle)
        else $error("engine idle right after a command was taken");

    a_done_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> out_free)
        else $error("result handed over while the output register is full");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> stat.idle)
        else $error("engine not idle after handing over a result");

endmodule
`default_nettype wire
